// ----- rtl/core/bpa_pkg.sv -----
// shared types and constants of the bump page allocator
`default_nettype none

package bpa_pkg;

  localparam int ADDR_W    = 48;
  localparam int PAGES_W   = 21;
  localparam int STATUS_W  = 3;
  localparam int CFG_W     = 48;
  localparam int CFG_IDX_W = 1;

  // request kinds
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_SIZE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 3'd0,
    ST_TABLE_FULL   = 3'd1,
    ST_NO_SPACE     = 3'd2,
    ST_NOT_FOUND    = 3'd3,
    ST_ALREADY_FREE = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_DECIDE,
    FSM_SCAN,
    FSM_ADDR,
    FSM_RESULT
  } fsm_t;

  // one region table entry
  typedef struct packed {
    logic [PAGES_W-1:0] offset;
    logic [PAGES_W-1:0] pages;
    logic               live;
  } entry_t;

endpackage

`default_nettype wire

// ----- rtl/core/bpa_if.sv -----
// request and response channel interfaces of the bump page allocator
`default_nettype none

interface bpa_req_if;
  logic                        valid;
  logic                        ready;
  logic                        req_type;
  logic [bpa_pkg::PAGES_W-1:0] page_count;
  logic [bpa_pkg::ADDR_W-1:0]  free_address;

  modport source (output valid, req_type, page_count, free_address, input ready);
  modport sink   (input valid, req_type, page_count, free_address, output ready);
endinterface

interface bpa_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [bpa_pkg::ADDR_W-1:0]   alloc_address;
  logic [bpa_pkg::STATUS_W-1:0] status;

  modport source (output valid, alloc_address, status, input ready);
  modport sink   (input valid, alloc_address, status, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/bump_page_allocator_first_fit_reuse_core.sv -----
// bump page allocator with first-fit reuse of freed table entries
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+--------------------------------------
//  req      | in  | valid/ready        | req_type, page_count, free_address
//  rsp      | out | valid/ready        | alloc_address, status
//  cfg      | in  | cfg_wr_en (no wait)| cfg_index, cfg_data
//
//  one request at a time; from accept to the result register a table-full
//  refusal passes through DECIDE, a bump allocation through DECIDE and ADDR,
//  a search through DECIDE and SCAN until a hit or the end of the table
//  the search walks the table one entry a cycle through the single read port
//  reset is synchronous and clears counters, cursor and configuration; the
//  table memory itself is not cleared, only entries below entry_count are read
//  a result waits in the output register while the next request is taken in;
//  that request only stalls at its own hand-over if rsp is still held
`default_nettype none

module bump_page_allocator_first_fit_reuse_core #(
  parameter int MAX_REGIONS = 512,
  parameter int PAGE_SIZE   = 4096
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_wr_en,
  input  wire logic [bpa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [bpa_pkg::CFG_W-1:0]     cfg_data,
  bpa_req_if.sink                            req,
  bpa_rsp_if.source                          rsp
);

  localparam int ADDR_W  = bpa_pkg::ADDR_W;
  localparam int PAGES_W = bpa_pkg::PAGES_W;
  localparam int IDX_W   = $clog2(MAX_REGIONS);
  localparam int CNT_W   = $clog2(MAX_REGIONS + 1);
  localparam int PS_W    = $clog2(PAGE_SIZE + 1);
  localparam int PROD_W  = PAGES_W + PS_W;

  localparam logic [CNT_W-1:0]  MAX_CNT = CNT_W'(MAX_REGIONS);
  localparam logic [PROD_W-1:0] PS_MUL  = PROD_W'(PAGE_SIZE);

  // configuration
  logic [ADDR_W-1:0]  base_address;
  logic [PAGES_W-1:0] region_size;

  // allocator state
  logic [CNT_W-1:0]   entry_count, entry_count_next;
  logic [CNT_W-1:0]   live_count, live_count_next;
  logic [PAGES_W-1:0] cursor_pages, cursor_pages_next;

  // latched request
  logic               req_free;
  logic [PAGES_W-1:0] req_pages;
  logic [ADDR_W-1:0]  req_addr;

  bpa_pkg::fsm_t state, state_next;

  // table memory
  bpa_pkg::entry_t mem [MAX_REGIONS];
  bpa_pkg::entry_t rd_data;
  logic            wr_en;
  logic [IDX_W-1:0] wr_idx;
  bpa_pkg::entry_t wr_data;

  // search pipeline: read issue, memory data, product
  logic [CNT_W-1:0]   rd_idx, rd_idx_next;
  logic               issue;
  logic               p1_vld;
  logic [IDX_W-1:0]   p1_idx;
  logic               p2_vld, p2_vld_next;
  logic [IDX_W-1:0]   p2_idx;
  logic [PROD_W-1:0]  p2_prod;
  logic [PAGES_W-1:0] p2_offset;
  logic [PAGES_W-1:0] p2_pages;
  logic               p2_live;
  logic [PAGES_W-1:0] mul_in;
  logic [ADDR_W-1:0]  p2_addr;
  logic               hit;

  // pending result and output register
  logic [ADDR_W-1:0]     res_addr, res_addr_next;
  bpa_pkg::status_t      res_status, res_status_next;
  logic                  out_valid;
  logic                  out_load;
  logic [ADDR_W-1:0]     out_addr;
  bpa_pkg::status_t      out_status;

  logic                  fits;
  logic [PAGES_W:0]      cursor_sum;

  assign req.ready         = (state == bpa_pkg::FSM_IDLE);
  assign rsp.valid         = out_valid;
  assign rsp.alloc_address = out_addr;
  assign rsp.status        = out_status;

  // page address of the entry in the product stage
  assign p2_addr    = base_address + ADDR_W'(p2_prod);
  assign cursor_sum = {1'b0, cursor_pages} + {1'b0, req_pages};
  assign fits       = cursor_sum <= {1'b0, region_size};
  assign issue      = (state == bpa_pkg::FSM_SCAN) && (rd_idx < entry_count);
  assign mul_in     = (state == bpa_pkg::FSM_DECIDE) ? cursor_pages : rd_data.offset;

  always_comb begin
    if (req_free == bpa_pkg::REQ_FREE) begin
      hit = p2_vld && (p2_addr == req_addr);
    end else begin
      hit = p2_vld && !p2_live && (p2_pages >= req_pages);
    end
  end

  // next state, table writes and result
  always_comb begin
    state_next        = state;
    entry_count_next  = entry_count;
    live_count_next   = live_count;
    cursor_pages_next = cursor_pages;
    rd_idx_next       = rd_idx;
    res_addr_next     = res_addr;
    res_status_next   = res_status;
    wr_en             = 1'b0;
    wr_idx            = p2_idx;
    wr_data           = '{offset: p2_offset, pages: p2_pages, live: 1'b1};
    out_load          = 1'b0;
    p2_vld_next       = p1_vld && (state == bpa_pkg::FSM_SCAN) && !hit;

    unique case (state)
      bpa_pkg::FSM_IDLE: begin
        if (req.valid) begin
          state_next = bpa_pkg::FSM_DECIDE;
        end
      end

      bpa_pkg::FSM_DECIDE: begin
        res_addr_next = '0;
        rd_idx_next   = '0;
        if (req_free == bpa_pkg::REQ_FREE) begin
          state_next = bpa_pkg::FSM_SCAN;
        end else if (entry_count >= MAX_CNT) begin
          res_status_next = bpa_pkg::ST_TABLE_FULL;
          state_next      = bpa_pkg::FSM_RESULT;
        end else if (fits) begin
          // append at the bump cursor; address formed from the product next cycle
          wr_en             = 1'b1;
          wr_idx            = entry_count[IDX_W-1:0];
          wr_data           = '{offset: cursor_pages, pages: req_pages, live: 1'b1};
          entry_count_next  = entry_count + 1'b1;
          live_count_next   = live_count + 1'b1;
          cursor_pages_next = cursor_sum[PAGES_W-1:0];
          res_status_next   = bpa_pkg::ST_OK;
          state_next        = bpa_pkg::FSM_ADDR;
        end else begin
          state_next = bpa_pkg::FSM_SCAN;
        end
      end

      bpa_pkg::FSM_SCAN: begin
        if (issue) begin
          rd_idx_next = rd_idx + 1'b1;
        end
        if (hit) begin
          state_next = bpa_pkg::FSM_RESULT;
          if (req_free == bpa_pkg::REQ_FREE) begin
            if (!p2_live) begin
              res_status_next = bpa_pkg::ST_ALREADY_FREE;
            end else begin
              wr_en           = 1'b1;
              wr_data.live    = 1'b0;
              res_status_next = bpa_pkg::ST_OK;
              if (live_count > 1) begin
                live_count_next = live_count - 1'b1;
              end else begin
                // last live entry gone: table and cursor start over
                live_count_next   = '0;
                entry_count_next  = '0;
                cursor_pages_next = '0;
              end
            end
          end else begin
            // reuse of the first freed entry that is large enough
            wr_en           = 1'b1;
            live_count_next = live_count + 1'b1;
            res_addr_next   = p2_addr;
            res_status_next = bpa_pkg::ST_OK;
          end
        end else if (!issue && !p1_vld && !p2_vld) begin
          state_next = bpa_pkg::FSM_RESULT;
          if (req_free == bpa_pkg::REQ_FREE) begin
            res_status_next = bpa_pkg::ST_NOT_FOUND;
          end else begin
            res_status_next = bpa_pkg::ST_NO_SPACE;
          end
        end
      end

      bpa_pkg::FSM_ADDR: begin
        res_addr_next = p2_addr;
        state_next    = bpa_pkg::FSM_RESULT;
      end

      bpa_pkg::FSM_RESULT: begin
        if (!out_valid || rsp.ready) begin
          out_load   = 1'b1;
          state_next = bpa_pkg::FSM_IDLE;
        end
      end

      default: begin
        state_next = bpa_pkg::FSM_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= bpa_pkg::FSM_IDLE;
      base_address <= '0;
      region_size  <= '0;
      entry_count  <= '0;
      live_count   <= '0;
      cursor_pages <= '0;
      rd_idx       <= '0;
      p1_vld       <= 1'b0;
      p2_vld       <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      entry_count  <= entry_count_next;
      live_count   <= live_count_next;
      cursor_pages <= cursor_pages_next;
      rd_idx       <= rd_idx_next;
      p1_vld       <= issue;
      p2_vld       <= p2_vld_next;
      if (cfg_wr_en) begin
        unique case (cfg_index)
          bpa_pkg::CFG_BASE_ADDRESS: base_address <= cfg_data[ADDR_W-1:0];
          bpa_pkg::CFG_REGION_SIZE:  region_size  <= cfg_data[PAGES_W-1:0];
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      req_free  <= req.req_type;
      req_pages <= req.page_count;
      req_addr  <= req.free_address;
    end
    p1_idx     <= rd_idx[IDX_W-1:0];
    p2_idx     <= p1_idx;
    p2_prod    <= PROD_W'(mul_in) * PS_MUL;
    p2_offset  <= rd_data.offset;
    p2_pages   <= rd_data.pages;
    p2_live    <= rd_data.live;
    res_addr   <= res_addr_next;
    res_status <= res_status_next;
    if (out_load) begin
      out_addr   <= res_addr;
      out_status <= res_status;
    end
  end

  // table memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_data <= mem[rd_idx[IDX_W-1:0]];
    end
  end

endmodule

`default_nettype wire

// ----- tb/bump_page_allocator_first_fit_reuse_core_tb.sv -----
// self-checking testbench of the bump page allocator with first-fit reuse
module bump_page_allocator_first_fit_reuse_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bpa_pkg::*;

  // table depth and page size as built into the block under test
  localparam int TABLE_DEPTH = 512;
  localparam int PAGE_BYTES = 4096;
  localparam int MAX_REGION_PAGES = 1048576;
  // quiet cycles allowed before the run is called hung: room for a full table
  // search plus the longest receiver stall and sender gap
  localparam int WATCHDOG_LIMIT = 4000;
  // pause before a register write and at the end, well over the bump latency
  localparam int SETTLE_CYCLES = 12;

  // one expected result: granted base address and status
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    status_t           status;
  } grant_t;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  bpa_req_if req_ch ();
  bpa_rsp_if rsp_ch ();

  bump_page_allocator_first_fit_reuse_core dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .req      (req_ch),
    .rsp      (rsp_ch)
  );

  // ---------------------------------------------------------------------------
  // allocator predictor: its own copy of the region table and configuration
  // ---------------------------------------------------------------------------
  logic [PAGES_W-1:0] slot_offset [TABLE_DEPTH];
  logic [PAGES_W-1:0] slot_pages  [TABLE_DEPTH];
  bit                 slot_live   [TABLE_DEPTH];
  int                 slot_count;
  int                 live_slots;
  logic [PAGES_W-1:0] cursor;
  logic [ADDR_W-1:0]  cfg_base;
  logic [PAGES_W-1:0] cfg_max;

  // results still owed by the block, oldest first
  grant_t pending_grants[$];

  int error_count;
  int requests_sent;
  int frees_sent;
  int results_checked;
  int status_hits [5];
  int quiet_cycles;

  // sender burst state: a held valid carries straight on into the next transfer
  int burst_left;
  bit valid_held;

  // base of a page offset with the current base register, wrapping at 48 bits
  function automatic logic [ADDR_W-1:0] page_address(input logic [PAGES_W-1:0] offset);
    logic [ADDR_W-1:0] span;
    span = ADDR_W'(offset) * ADDR_W'(PAGE_BYTES);
    return cfg_base + span;
  endfunction

  function automatic logic [ADDR_W-1:0] random_word48();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[ADDR_W-1:0];
  endfunction

  // work out the result of one accepted request and move the table on
  function automatic grant_t apply_request(input logic kind, input logic [PAGES_W-1:0] pages,
                                           input logic [ADDR_W-1:0] addr);
    grant_t g;
    logic [PAGES_W:0] reach;
    int i;
    g.addr = '0;
    if (kind == REQ_ALLOC) begin
      g.status = ST_NO_SPACE;
      reach = {1'b0, cursor} + {1'b0, pages};
      if (slot_count >= TABLE_DEPTH) begin
        // table full wins even over a reusable entry
        g.status = ST_TABLE_FULL;
      end else if (reach <= {1'b0, cfg_max}) begin
        slot_offset[slot_count] = cursor;
        slot_pages[slot_count] = pages;
        slot_live[slot_count] = 1'b1;
        slot_count++;
        live_slots++;
        g.addr = page_address(cursor);
        g.status = ST_OK;
        cursor = reach[PAGES_W-1:0];
      end else begin
        for (i = 0; i < slot_count; i++) begin
          if (!slot_live[i] && slot_pages[i] >= pages) begin
            slot_live[i] = 1'b1;
            live_slots++;
            g.addr = page_address(slot_offset[i]);
            g.status = ST_OK;
            break;
          end
        end
      end
    end else begin
      g.status = ST_NOT_FOUND;
      for (i = 0; i < slot_count; i++) begin
        if (page_address(slot_offset[i]) == addr) begin
          if (!slot_live[i]) begin
            g.status = ST_ALREADY_FREE;
          end else begin
            slot_live[i] = 1'b0;
            if (live_slots > 0) live_slots--;
            if (live_slots == 0) begin
              slot_count = 0;
              cursor = '0;
            end
            g.status = ST_OK;
          end
          break;
        end
      end
    end
    return g;
  endfunction

  // random table index whose live flag matches, or -1 when there is none
  function automatic int pick_slot(input bit want_live);
    int hits;
    int choice;
    int i;
    hits = 0;
    for (i = 0; i < slot_count; i++) if (slot_live[i] == want_live) hits++;
    if (hits == 0) return -1;
    choice = $urandom_range(0, hits - 1);
    for (i = 0; i < slot_count; i++) begin
      if (slot_live[i] == want_live) begin
        if (choice == 0) return i;
        choice--;
      end
    end
    return -1;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch at %0t ns: %s got %0h expected %0h", $time, what, got, want);
    error_count++;
  endtask

  // ---------------------------------------------------------------------------
  // clock
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // request side: one transfer per call, then either carry on or back off
  // ---------------------------------------------------------------------------
  task automatic send_request(input logic kind, input logic [PAGES_W-1:0] pages,
                              input logic [ADDR_W-1:0] addr);
    grant_t want;
    int gap;
    req_ch.valid <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.page_count <= pages;
    req_ch.free_address <= addr;
    @(posedge clk);
    while (req_ch.ready !== 1'b1) @(posedge clk);
    // transfer taken at this edge: predict it straight away
    want = apply_request(kind, pages, addr);
    pending_grants.push_back(want);
    status_hits[int'(want.status)]++;
    requests_sent++;
    if (kind == REQ_FREE) frees_sent++;
    if (burst_left > 0) begin
      burst_left--;
      valid_held = 1'b1;
    end else begin
      // end of a burst: drop valid for a gap, sometimes a long one
      req_ch.valid <= 1'b0;
      valid_held = 1'b0;
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 90) : $urandom_range(1, 10);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(25, 60)
                                                : $urandom_range(0, 6);
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic request_alloc(input logic [PAGES_W-1:0] pages);
    send_request(REQ_ALLOC, pages, random_word48());
  endtask

  task automatic request_free(input logic [ADDR_W-1:0] addr);
    send_request(REQ_FREE, PAGES_W'($urandom_range(0, MAX_REGION_PAGES)), addr);
  endtask

  // let the block go idle: no valid held, every result back, a short pause
  task automatic settle_block();
    if (valid_held) begin
      req_ch.valid <= 1'b0;
      valid_held = 1'b0;
    end
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // both registers in back-to-back writes, only ever with the block idle
  task automatic program_region(input logic [ADDR_W-1:0] base, input logic [PAGES_W-1:0] pages);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_BASE_ADDRESS;
    cfg_data <= CFG_W'(base);
    @(posedge clk);
    cfg_index <= CFG_REGION_SIZE;
    cfg_data <= CFG_W'(pages);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cfg_base = base;
    cfg_max = pages;
  endtask

  // free every live entry so the table clears; offsets are distinct here
  task automatic drain_live();
    int k;
    int guard;
    for (guard = 0; live_slots > 0 && guard < TABLE_DEPTH; guard++) begin
      for (k = 0; k < slot_count && !slot_live[k]; k++) ;
      request_free(page_address(slot_offset[k]));
    end
  endtask

  // ---------------------------------------------------------------------------
  // result side: stall pattern of its own, stepping through five patterns in turn
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned tick;
    int unsigned pattern;
    rsp_ch.ready <= 1'b0;
    tick = 0;
    forever begin
      @(posedge clk);
      tick++;
      pattern = (tick >> 9) % 5;
      case (pattern)
        0: rsp_ch.ready <= 1'b1;                          // no stalls at all
        1: rsp_ch.ready <= 1'($urandom_range(0, 1));      // coin toss
        2: rsp_ch.ready <= (tick % 7) < 2;                // mostly stalled
        3: rsp_ch.ready <= ((tick >> 4) & 1) == 0;        // on and off in equal runs
        default: rsp_ch.ready <= $urandom_range(0, 9) != 0;
      endcase
    end
  end

  // check each result transfer against the oldest expectation
  always @(posedge clk) begin
    grant_t want;
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      if (pending_grants.size() == 0) begin
        report_mismatch("result with nothing outstanding, status", 64'(rsp_ch.status), 64'd0);
      end else begin
        want = pending_grants.pop_front();
        if (rsp_ch.alloc_address !== want.addr)
          report_mismatch("alloc_address", 64'(rsp_ch.alloc_address), 64'(want.addr));
        if (rsp_ch.status !== want.status)
          report_mismatch("status", 64'(rsp_ch.status), 64'(want.status));
        results_checked++;
      end
    end
  end

  // watchdog: any transfer on either channel counts as progress
  always @(posedge clk) begin
    if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
        (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: %0d cycles without a transfer, %0d results outstanding",
               quiet_cycles, pending_grants.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // directed tests
  // ---------------------------------------------------------------------------

  // bump, no space, free, double free, unknown addresses, reuse of a freed entry
  task automatic test_bump_and_reuse();
    settle_block();
    program_region(48'h0000_7654_3000, 21'd16);
    request_alloc(21'd4);                      // offset 0
    request_alloc(21'd12);                     // offset 4, region now exactly full
    request_alloc(21'd0);                      // zero-size entry right at the end
    request_alloc(21'd1);                      // nothing freed yet: no space
    request_free(page_address(21'd4));
    request_free(page_address(21'd4));         // double free
    request_free(page_address(21'd0) + 48'd1); // misaligned, unknown
    request_free('1);
    request_free('0);
    request_alloc(21'(MAX_REGION_PAGES));      // larger than any freed entry
    request_alloc(21'd5);                      // first fit into the freed 12 pages
    request_free(page_address(21'd0));
    request_free(page_address(21'd16));
  endtask

  // region size lowered under the cursor: only reuse, zero pages take any size
  task automatic test_cursor_beyond_region();
    settle_block();
    program_region(cfg_base, 21'd8);
    request_alloc(21'd0);                      // reuses the first freed entry
    request_alloc(21'd2);                      // only a zero-size entry left: no space
    request_alloc(21'd0);                      // takes the zero-size entry
    request_free(page_address(21'd4));
    request_free(page_address(21'd0));
    request_free(page_address(21'd16));        // last live entry: table clears
    request_alloc(21'd3);                      // bump from offset 0 again
  endtask

  // all-ones base with the largest region: addresses wrap at 48 bits
  task automatic test_address_extremes();
    settle_block();
    program_region('1, 21'(MAX_REGION_PAGES));
    request_free(page_address(21'd0));         // live entry seen under the new base
    request_alloc(21'(MAX_REGION_PAGES));      // whole region in one go
    request_alloc(21'd0);                      // zero-size entry at the very end
    request_free(page_address(21'(MAX_REGION_PAGES)));
    request_free('1);
  endtask

  // empty region: only a zero-size request can bump
  task automatic test_empty_region();
    settle_block();
    program_region('0, '0);
    request_alloc(21'd0);
    request_alloc(21'd1);
    request_free('0);
  endtask

  // ---------------------------------------------------------------------------
  // random traffic in phases, each under its own region setting
  // ---------------------------------------------------------------------------
  task automatic random_request(input bit allow_zero_append);
    int r;
    int k;
    int span;
    int alloc_share;
    logic [PAGES_W-1:0] pages;
    logic [ADDR_W-1:0] addr;
    span = int'(cfg_max);
    // keep the table short so searches stay quick
    alloc_share = (slot_count > 150) ? 30 : 55;
    if ($urandom_range(0, 99) < alloc_share) begin
      r = $urandom_range(0, 99);
      if (r < 60) pages = PAGES_W'($urandom_range(1, span / 6 + 1));
      else if (r < 75) pages = PAGES_W'($urandom_range(0, (span + 2 > MAX_REGION_PAGES) ?
                                                          MAX_REGION_PAGES : span + 2));
      else if (r < 85) pages = PAGES_W'($urandom_range(0, MAX_REGION_PAGES));
      else if (r < 90) pages = 21'(MAX_REGION_PAGES);
      else pages = '0;
      // a zero-size entry followed by another at the same offset could never
      // be freed, so zero pages here only where they go to the reuse search
      if (!allow_zero_append && pages == 0 && cursor <= cfg_max) pages = 21'd1;
      request_alloc(pages);
    end else begin
      r = $urandom_range(0, 99);
      k = -1;
      if (r < 65) k = pick_slot(1'b1);
      else if (r < 80) k = pick_slot(1'b0);
      if (k >= 0) addr = page_address(slot_offset[k]);
      else if (r % 2 == 0) addr = random_word48();
      else addr = page_address(cursor) + ADDR_W'($urandom_range(0, PAGE_BYTES - 1));
      request_free(addr);
    end
  endtask

  task automatic test_random_traffic();
    int phase;
    int step;
    int steps;
    logic [ADDR_W-1:0] base;
    logic [PAGES_W-1:0] pages;
    settle_block();
    drain_live();
    for (phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin
          base = random_word48() & ~ADDR_W'(PAGE_BYTES - 1);
          pages = PAGES_W'($urandom_range(8, 40));
          steps = 110;
        end
        1: begin
          base = random_word48();
          pages = PAGES_W'($urandom_range(1, MAX_REGION_PAGES));
          steps = 110;
        end
        2: begin
          base = '0;
          pages = '0;
          steps = 20;
        end
        3: begin
          base = '1;
          pages = 21'(MAX_REGION_PAGES);
          steps = 110;
        end
        default: begin
          base = random_word48() & ~ADDR_W'(PAGE_BYTES - 1);
          pages = PAGES_W'($urandom_range(16, 200));
          steps = 110;
        end
      endcase
      settle_block();
      program_region(base, pages);
      for (step = 0; step < steps; step++) begin
        // odd phases shrink the region half way, often under the cursor
        if (phase % 2 == 1 && step == steps / 2) begin
          settle_block();
          program_region(base, PAGES_W'($urandom_range(0, int'(cursor))));
        end
        random_request(1'b0);
      end
      drain_live();
    end
  endtask

  // duplicate bases, then fill the table until it reports full
  task automatic test_table_full();
    int k;
    settle_block();
    program_region(random_word48() & ~ADDR_W'(PAGE_BYTES - 1), 21'(MAX_REGION_PAGES));
    request_alloc(21'd0);                      // zero-size entry at offset 0
    request_alloc(21'd3);                      // same base as the entry before it
    request_free(page_address(21'd0));         // acts on the first match only
    request_free(page_address(21'd0));         // first match already free
    while (slot_count < TABLE_DEPTH) begin
      k = pick_slot(1'b1);
      if ($urandom_range(0, 9) == 0 && k >= 0) request_free(page_address(slot_offset[k]));
      else request_alloc(PAGES_W'($urandom_range(0, 3)));
    end
    k = pick_slot(1'b1);
    request_free(page_address(slot_offset[k]));
    // a freed entry is there to reuse, but a full table refuses first
    request_alloc(21'd0);
    request_alloc(21'd1);
    request_alloc(21'(MAX_REGION_PAGES));
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst <= 1'b1;
    cfg_wr_en <= 1'b0;
    cfg_index <= CFG_BASE_ADDRESS;
    cfg_data <= '0;
    req_ch.valid <= 1'b0;
    req_ch.req_type <= REQ_ALLOC;
    req_ch.page_count <= '0;
    req_ch.free_address <= '0;
    // predictor starts as the block does after reset
    slot_count = 0;
    live_slots = 0;
    cursor = '0;
    cfg_base = '0;
    cfg_max = '0;
    error_count = 0;
    requests_sent = 0;
    frees_sent = 0;
    results_checked = 0;
    quiet_cycles = 0;
    burst_left = 0;
    valid_held = 1'b0;
    foreach (status_hits[i]) status_hits[i] = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_bump_and_reuse();
    test_cursor_beyond_region();
    test_address_extremes();
    test_empty_region();
    test_random_traffic();
    test_table_full();
    settle_block();

    $display("covered %0d requests (%0d allocate, %0d free), %0d results checked",
             requests_sent, requests_sent - frees_sent, frees_sent, results_checked);
    $display("status mix: ok %0d, table full %0d, no space %0d, not found %0d, double free %0d",
             status_hits[0], status_hits[1], status_hits[2], status_hits[3], status_hits[4]);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
